/* sv/spt_pkg.sv */
// Shared types, neighbourhood geometry and adjacency tables for the simple-point test.
`timescale 1ns / 1ps

package spt_pkg;

	localparam int NB_COUNT = 26;
	localparam int CNT_W    = 4;
	localparam int BG_W     = 3;

	typedef logic [NB_COUNT-1:0] nb_t;
	typedef logic [NB_COUNT-1:0][NB_COUNT-1:0] adj_t;

	// Offsets of neighbour k, centre skipped
	function automatic int nb_x(int k);
		int p;
		p = (k < 13) ? k : k + 1;
		return p % 3 - 1;
	endfunction

	function automatic int nb_y(int k);
		int p;
		p = (k < 13) ? k : k + 1;
		return (p / 3) % 3 - 1;
	endfunction

	function automatic int nb_z(int k);
		int p;
		p = (k < 13) ? k : k + 1;
		return p / 9 - 1;
	endfunction

	function automatic int iabs(int v);
		return (v < 0) ? -v : v;
	endfunction

	// Row k holds the neighbours of position k: face-adjacent or 26-adjacent
	function automatic adj_t adj_table(bit face);
		adj_t m;
		int ax;
		int ay;
		int az;
		m = '0;
		for (int k = 0; k < NB_COUNT; k++) begin
			for (int j = 0; j < NB_COUNT; j++) begin
				ax = iabs(nb_x(j) - nb_x(k));
				ay = iabs(nb_y(j) - nb_y(k));
				az = iabs(nb_z(j) - nb_z(k));
				if (j != k) begin
					if (face) begin
						if (ax + ay + az == 1)
							m[k][j] = 1'b1;
					end else if (ax <= 1 && ay <= 1 && az <= 1) begin
						m[k][j] = 1'b1;
					end
				end
			end
		end
		return m;
	endfunction

	// Positions whose city-block distance from the centre lies in [lo, hi]
	function automatic nb_t shell_mask(int lo, int hi);
		nb_t m;
		int d;
		m = '0;
		for (int k = 0; k < NB_COUNT; k++) begin
			d = iabs(nb_x(k)) + iabs(nb_y(k)) + iabs(nb_z(k));
			if (d >= lo && d <= hi)
				m[k] = 1'b1;
		end
		return m;
	endfunction

	localparam adj_t ADJ_26     = adj_table(1'b0);
	localparam adj_t ADJ_6      = adj_table(1'b1);
	localparam nb_t  SHELL_18   = shell_mask(1, 2);
	localparam nb_t  SHELL_FACE = shell_mask(1, 1);
	localparam nb_t  NB_ALL     = '1;

	// One result beat
	typedef struct packed {
		logic             deletable;
		logic [CNT_W-1:0] fg;
		logic [BG_W-1:0]  bg;
	} res_t;

endpackage

/* sv/spt_components.sv */
// Connected-component counter over the 26 neighbour positions.
`timescale 1ns / 1ps

module spt_components (
	input  spt_pkg::nb_t                 set,
	input  spt_pkg::adj_t                adj,
	input  spt_pkg::nb_t                 need,
	output logic [spt_pkg::CNT_W-1:0]    count
);
	import spt_pkg::*;

	localparam int SQUARINGS = $clog2(NB_COUNT);

	adj_t reach;
	adj_t nxt;
	nb_t  leader;
	nb_t  lower;

	// Close the reachability relation by repeated squaring, then count one leader
	// (lowest index) per component that meets the required mask
	always_comb begin
		for (int i = 0; i < NB_COUNT; i++) begin
			reach[i] = set[i] ? (adj[i] & set) : '0;
			reach[i][i] = set[i];
		end
		for (int s = 0; s < SQUARINGS; s++) begin
			for (int i = 0; i < NB_COUNT; i++) begin
				nxt[i] = reach[i];
				for (int j = 0; j < NB_COUNT; j++)
					if (reach[i][j])
						nxt[i] = nxt[i] | reach[j];
			end
			reach = nxt;
		end
		for (int i = 0; i < NB_COUNT; i++) begin
			lower = '0;
			for (int j = 0; j < NB_COUNT; j++)
				lower[j] = (j < i);
			leader[i] = set[i] && ((reach[i] & lower) == '0) && ((reach[i] & need) != '0);
		end
		count = CNT_W'($countones(leader));
	end

endmodule

/* sv/spt_classify.sv */
// Foreground and background component counts and the deletable decision.
`timescale 1ns / 1ps

module spt_classify (
	input  spt_pkg::nb_t  nb,
	output spt_pkg::res_t res
);
	import spt_pkg::*;

	nb_t              bg_set;
	logic [CNT_W-1:0] fg_cnt;
	logic [CNT_W-1:0] bg_cnt;

	// Background within the 18-neighbourhood, corners excluded
	assign bg_set = ~nb & SHELL_18;

	spt_components u_fg (
		.set   (nb),
		.adj   (ADJ_26),
		.need  (NB_ALL),
		.count (fg_cnt)
	);

	spt_components u_bg (
		.set   (bg_set),
		.adj   (ADJ_6),
		.need  (SHELL_FACE),
		.count (bg_cnt)
	);

	// Simple point when both counts are one
	always_comb begin
		res.fg        = fg_cnt;
		res.bg        = bg_cnt[BG_W-1:0];
		res.deletable = (fg_cnt == CNT_W'(1)) && (bg_cnt == CNT_W'(1));
	end

endmodule

/* sv/simple_point_test_26_6_core.sv */
// Top level of the (26,6) simple-point test: input register, classifier, result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------------
//  in      | sink      | in_valid, in_stall   | neighbourhood[25:0]
//  out     | source    | out_valid, out_stall | deletable, foreground_components[3:0],
//          |           |                      | background_components[2:0]
//
// One beat per cycle sustained unless out_stall is high; beats pass input and result registers.
// The depth is set by the reachability closure (five squarings) between the two registers.
// arst_n clears both valid flags; payload registers are not reset.
// A stalled result holds; the input register still takes a beat while the result waits,
// so in_stall rises only when both registers are full and out_stall is high.
`timescale 1ns / 1ps

module simple_point_test_26_6_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  spt_pkg::nb_t                 neighbourhood,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         deletable,
	output logic [spt_pkg::CNT_W-1:0]    foreground_components,
	output logic [spt_pkg::BG_W-1:0]     background_components
);
	import spt_pkg::*;

	logic valid_s1;
	nb_t  nb_s1;
	res_t res_c;
	res_t res_q;
	logic out_valid_q;
	logic load_out;
	logic load_s1;

	// Advance the input stage when the result register is free or being drained
	assign load_out = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !load_out;
	assign load_s1  = in_valid && !in_stall;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || load_out) begin
			valid_s1 <= load_s1;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (load_s1) begin
			nb_s1 <= neighbourhood;
		end
	end

	spt_classify u_classify (
		.nb  (nb_s1),
		.res (res_c)
	);

	// Result valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q <= res_c;
		end
	end

	assign out_valid             = out_valid_q;
	assign deletable             = res_q.deletable;
	assign foreground_components = res_q.fg;
	assign background_components = res_q.bg;

	// Counts stay in range whenever a result is shown
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.fg <= CNT_W'(8)) && (res_q.bg <= BG_W'(6)))
		else $error("component count out of range");

	// Deletable only when both counts are one
	a_deletable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.deletable == ((res_q.fg == CNT_W'(1)) && (res_q.bg == BG_W'(1)))))
		else $error("deletable disagrees with counts");

	// An input stage that cannot advance keeps its beat
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_out |=> valid_s1 && $stable(nb_s1))
		else $error("input stage lost a beat");

	// A beat taken at the input reaches the input stage
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |=> valid_s1)
		else $error("accepted beat not held");

endmodule
